@@ design/rtys_pkg.sv @@
// Shared types, widths and constants for the RGB to YCbCr subsampler.
package rtys_pkg;

	// Channel fixed point: 2**CHANNEL_FRACTION_BITS is one
	localparam int CHANNEL_FRACTION_BITS = 12;
	localparam int F = CHANNEL_FRACTION_BITS;

	// Clamped channel, 0..one
	localparam int CH_W  = F + 1;
	// Unsigned weight times channel
	localparam int P_W   = F + 17;
	// Channel term plus half offset, unsigned
	localparam int T_W   = F + 18;
	// Signed component value fed to the mapping stage
	localparam int V_W   = F + 19;
	// Mapped numerator, signed
	localparam int N_W   = F + 37;
	// Clamped numerator, unsigned, up to the denominator
	localparam int D_W   = F + 34;
	// Numerator times 255 plus half the denominator
	localparam int X_W   = F + 42;
	// Scaled dividend and quotient of the final divide
	localparam int TQ_W  = 24;
	localparam int QUO_W = 8;

	// Q16 weights, coefficients and range ends
	localparam int K_W    = 16;
	localparam int W_W    = 17;
	localparam int SPAN_W = 18;
	localparam int LOWB_W = 34;
	localparam logic [W_W-1:0] ONE_Q16 = 17'h10000;

	// Queue between front and back
	localparam int Q_DEPTH = 8;
	localparam int Q_AW    = 3;
	localparam int FS_CNT_W = 3;
	localparam int OCC_W   = Q_AW + 2;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KB          = 3'd0,
		CFG_KR          = 3'd1,
		CFG_FORMAT      = 3'd2,
		CFG_LUMA_LOW    = 3'd3,
		CFG_LUMA_HIGH   = 3'd4,
		CFG_CHROMA_LOW  = 3'd5,
		CFG_CHROMA_HIGH = 3'd6
	} cfg_reg_t;

	// Chroma format codes; the unused fourth code acts as full resolution
	localparam logic [1:0] FMT_420 = 2'd0;
	localparam logic [1:0] FMT_422 = 2'd1;
	localparam logic [1:0] FMT_444 = 2'd2;

	// Reset values
	localparam logic [K_W-1:0] KB_RESET = 16'd4732;
	localparam logic [K_W-1:0] KR_RESET = 16'd13933;
	localparam logic [1:0]     FMT_RESET = FMT_420;
	localparam logic [W_W-1:0] LOW_RESET  = 17'd0;
	localparam logic [W_W-1:0] HIGH_RESET = ONE_Q16;

	typedef enum logic [1:0] {
		PLANE_Y  = 2'd0,
		PLANE_CB = 2'd1,
		PLANE_CR = 2'd2
	} plane_t;

	// Register contents plus the values derived from them
	typedef struct packed {
		logic [K_W-1:0]           kb;
		logic [K_W-1:0]           kr;
		logic signed [SPAN_W-1:0] kg;
		logic [W_W-1:0]           wb;
		logic [W_W-1:0]           wr;
		logic [1:0]               fmt;
		logic [W_W-1:0]           luma_low;
		logic [W_W-1:0]           chroma_low;
		logic signed [SPAN_W-1:0] luma_span;
		logic signed [SPAN_W-1:0] chroma_span;
	} cfg_t;

	// One classified pixel waiting for the back end
	typedef struct packed {
		logic signed [V_W-1:0] vy;
		logic signed [V_W-1:0] vb;
		logic signed [V_W-1:0] vr;
		logic                  keep;
	} pix_t;

	// Front status towards the top level
	typedef struct packed {
		logic                push;
		logic [FS_CNT_W-1:0] inflight;
	} front_stat_t;

endpackage

@@ design/rtys_cfg.sv @@
// Configuration register file and derived coefficients.
module rtys_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rtys_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rtys_pkg::CFG_DATA_W-1:0]  cfg_data,
	output rtys_pkg::cfg_t                   cfg
);

	logic [rtys_pkg::K_W-1:0] kb_q;
	logic [rtys_pkg::K_W-1:0] kr_q;
	logic [1:0]               fmt_q;
	logic [rtys_pkg::W_W-1:0] luma_low_q;
	logic [rtys_pkg::W_W-1:0] luma_high_q;
	logic [rtys_pkg::W_W-1:0] chroma_low_q;
	logic [rtys_pkg::W_W-1:0] chroma_high_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;

	// Register writes, truncated to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kb_q          <= rtys_pkg::KB_RESET;
			kr_q          <= rtys_pkg::KR_RESET;
			fmt_q         <= rtys_pkg::FMT_RESET;
			luma_low_q    <= rtys_pkg::LOW_RESET;
			luma_high_q   <= rtys_pkg::HIGH_RESET;
			chroma_low_q  <= rtys_pkg::LOW_RESET;
			chroma_high_q <= rtys_pkg::HIGH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rtys_pkg::CFG_KB:          kb_q          <= cfg_data[rtys_pkg::K_W-1:0];
				rtys_pkg::CFG_KR:          kr_q          <= cfg_data[rtys_pkg::K_W-1:0];
				rtys_pkg::CFG_FORMAT:      fmt_q         <= cfg_data[1:0];
				rtys_pkg::CFG_LUMA_LOW:    luma_low_q    <= cfg_data;
				rtys_pkg::CFG_LUMA_HIGH:   luma_high_q   <= cfg_data;
				rtys_pkg::CFG_CHROMA_LOW:  chroma_low_q  <= cfg_data;
				rtys_pkg::CFG_CHROMA_HIGH: chroma_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Derived values: green weight, chroma divisors, range spans
	always_comb begin
		cfg.kb  = kb_q;
		cfg.kr  = kr_q;
		cfg.kg  = $signed(18'(rtys_pkg::ONE_Q16) - 18'(kr_q) - 18'(kb_q));
		cfg.wb  = rtys_pkg::ONE_Q16 - 17'(kb_q);
		cfg.wr  = rtys_pkg::ONE_Q16 - 17'(kr_q);
		cfg.fmt = fmt_q;
		cfg.luma_low    = luma_low_q;
		cfg.chroma_low  = chroma_low_q;
		cfg.luma_span   = $signed({1'b0, luma_high_q}) - $signed({1'b0, luma_low_q});
		cfg.chroma_span = $signed({1'b0, chroma_high_q}) - $signed({1'b0, chroma_low_q});
	end

endmodule

@@ design/rtys_front.sv @@
// Front end: clamps channels, classifies chroma keep, forms luma and colour differences.
module rtys_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic signed [15:0]       red,
	input  logic signed [15:0]       green,
	input  logic signed [15:0]       blue,
	input  logic                     column_odd,
	input  logic                     row_odd,
	input  rtys_pkg::cfg_t           cfg,
	output rtys_pkg::front_stat_t    stat,
	output rtys_pkg::pix_t           push_data
);

	localparam logic signed [15:0] CH_ONE = 16'(2 ** rtys_pkg::F);

	logic                         valid_s1, valid_s2, valid_s3, valid_s4;
	logic [rtys_pkg::CH_W-1:0]    r_s1, g_s1, b_s1;
	logic                         keep_s1, keep_s2, keep_s3, keep_s4;
	logic [rtys_pkg::P_W-1:0]     pr_s2, pb_s2;
	logic signed [rtys_pkg::V_W-1:0] pg_s2;
	logic [rtys_pkg::T_W-1:0]     bterm_s2, rterm_s2, bterm_s3, rterm_s3;
	logic signed [rtys_pkg::V_W-1:0] y_s3;
	logic signed [rtys_pkg::V_W-1:0] vy_s4, vb_s4, vr_s4;
	logic [rtys_pkg::CH_W-1:0]    r_cl, g_cl, b_cl;
	logic                         keep_in;

	function automatic logic [rtys_pkg::CH_W-1:0] clamp_ch(input logic signed [15:0] v);
		logic [rtys_pkg::CH_W-1:0] res;
		if (v < 0)
			res = '0;
		else if (v > CH_ONE)
			res = rtys_pkg::CH_W'(CH_ONE);
		else
			res = rtys_pkg::CH_W'(v);
		return res;
	endfunction

	// Clamp and keep decision
	always_comb begin
		r_cl = clamp_ch(red);
		g_cl = clamp_ch(green);
		b_cl = clamp_ch(blue);
		priority if (cfg.fmt == rtys_pkg::FMT_420)
			keep_in = !column_odd && !row_odd;
		else if (cfg.fmt == rtys_pkg::FMT_422)
			keep_in = !column_odd;
		else
			keep_in = 1'b1;
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Datapath: s1 clamped input, s2 weighted channels, s3 luma, s4 differences
	always_ff @(posedge clk) begin
		if (accept) begin
			r_s1    <= r_cl;
			g_s1    <= g_cl;
			b_s1    <= b_cl;
			keep_s1 <= keep_in;
		end
		pr_s2    <= cfg.kr * r_s1;
		pb_s2    <= cfg.kb * b_s1;
		pg_s2    <= cfg.kg * $signed({1'b0, g_s1});
		bterm_s2 <= (rtys_pkg::T_W'(b_s1) << 16) + (rtys_pkg::T_W'(cfg.wb) << rtys_pkg::F);
		rterm_s2 <= (rtys_pkg::T_W'(r_s1) << 16) + (rtys_pkg::T_W'(cfg.wr) << rtys_pkg::F);
		keep_s2  <= keep_s1;

		y_s3     <= $signed(rtys_pkg::V_W'(pr_s2)) + pg_s2 + $signed(rtys_pkg::V_W'(pb_s2));
		bterm_s3 <= bterm_s2;
		rterm_s3 <= rterm_s2;
		keep_s3  <= keep_s2;

		// luma doubled so it shares the chroma mapping with a unit divisor
		vy_s4   <= y_s3 <<< 1;
		vb_s4   <= $signed(rtys_pkg::V_W'(bterm_s3)) - y_s3;
		vr_s4   <= $signed(rtys_pkg::V_W'(rterm_s3)) - y_s3;
		keep_s4 <= keep_s3;
	end

	// Queue push and in-flight count for the credit check
	always_comb begin
		stat.push     = valid_s4;
		stat.inflight = rtys_pkg::FS_CNT_W'(valid_s1) + rtys_pkg::FS_CNT_W'(valid_s2)
			+ rtys_pkg::FS_CNT_W'(valid_s3) + rtys_pkg::FS_CNT_W'(valid_s4);
		push_data.vy   = vy_s4;
		push_data.vb   = vb_s4;
		push_data.vr   = vr_s4;
		push_data.keep = keep_s4;
	end

endmodule

@@ design/rtys_queue.sv @@
// Short FIFO of classified pixels between front and back.
module rtys_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  rtys_pkg::pix_t            push_data,
	input  logic                      pop,
	output rtys_pkg::pix_t            head,
	output logic                      empty,
	output logic [rtys_pkg::Q_AW:0]   count
);

	rtys_pkg::pix_t               mem_q [rtys_pkg::Q_DEPTH];
	logic [rtys_pkg::Q_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [rtys_pkg::Q_AW:0]      count_q;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

`ifndef ASSERT_OFF
	// The credit check upstream must never let the queue overflow
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && count_q == (rtys_pkg::Q_AW+1)'(rtys_pkg::Q_DEPTH)))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");
`endif

endmodule

@@ design/rtys_back.sv @@
// Back end: sequences Y per pixel, plus Cb and Cr at kept chroma positions, and maps each to a rounded byte.
module rtys_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rtys_pkg::cfg_t        cfg,
	input  rtys_pkg::pix_t        head,
	input  logic                  empty,
	output logic                  pop,
	output logic                  result_valid,
	output logic [1:0]            plane,
	output logic [7:0]            sample_byte,
	output logic                  last_of_pixel
);

	typedef struct packed {
		logic [rtys_pkg::TQ_W-1:0] rem;
		logic [1:0]                q;
	} div_t;

	rtys_pkg::plane_t seq_q, seq_d;
	logic issue, job_last;
	logic signed [rtys_pkg::V_W-1:0]    job_v;
	logic [rtys_pkg::W_W-1:0]           job_w, job_low;
	logic signed [rtys_pkg::SPAN_W-1:0] job_span;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9;
	rtys_pkg::plane_t plane_s1, plane_s2, plane_s3, plane_s4, plane_s5;
	rtys_pkg::plane_t plane_s6, plane_s7, plane_s8, plane_s9;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7, last_s8, last_s9;
	logic [rtys_pkg::W_W-1:0] w_s1, w_s2, w_s3, w_s4, w_s5, w_s6, w_s7, w_s8;
	logic signed [rtys_pkg::V_W-1:0]    v_s1;
	logic [rtys_pkg::W_W-1:0]           low_s1;
	logic signed [rtys_pkg::SPAN_W-1:0] span_s1;
	logic signed [rtys_pkg::N_W-1:0]    prod_a_s2;
	logic [rtys_pkg::LOWB_W-1:0]        prod_b_s2;
	logic signed [rtys_pkg::N_W-1:0]    num_s3;
	logic [rtys_pkg::D_W-1:0]           n_s4;
	logic [rtys_pkg::TQ_W-1:0]          t_s5, rem_s6, rem_s7, rem_s8;
	logic [rtys_pkg::QUO_W-1:0]         q_s6, q_s7, q_s8, q_s9;

	logic signed [rtys_pkg::N_W-1:0] den3;
	logic [rtys_pkg::X_W-1:0]        x4;
	div_t ds6, ds7, ds8, ds9;

	// Two restoring quotient bits, top bit weight 2**hi
	function automatic div_t div_step2(input logic [rtys_pkg::TQ_W-1:0] rem,
			input logic [rtys_pkg::W_W-1:0] w, input int hi);
		logic [rtys_pkg::TQ_W:0]   d;
		logic [rtys_pkg::TQ_W-1:0] r;
		div_t res;
		r = rem;
		res.q = '0;
		for (int k = 0; k < 2; k++) begin
			d = (rtys_pkg::TQ_W+1)'(w) << (hi - k);
			if ({1'b0, r} >= d) begin
				r = rtys_pkg::TQ_W'({1'b0, r} - d);
				res.q[1-k] = 1'b1;
			end
		end
		res.rem = r;
		return res;
	endfunction

	// Sequencer state: which plane of the head pixel goes next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seq_q <= rtys_pkg::PLANE_Y;
		else
			seq_q <= seq_d;
	end

	// Sequencer next state
	always_comb begin
		seq_d = seq_q;
		unique case (seq_q)
			rtys_pkg::PLANE_Y:  if (!empty && head.keep) seq_d = rtys_pkg::PLANE_CB;
			rtys_pkg::PLANE_CB: if (!empty) seq_d = rtys_pkg::PLANE_CR;
			rtys_pkg::PLANE_CR: if (!empty) seq_d = rtys_pkg::PLANE_Y;
			default:            seq_d = rtys_pkg::PLANE_Y;
		endcase
	end

	// Sequencer outputs: job selection and queue pop
	always_comb begin
		issue    = !empty;
		job_last = 1'b0;
		job_v    = head.vy;
		job_w    = rtys_pkg::ONE_Q16;
		job_span = cfg.luma_span;
		job_low  = cfg.luma_low;
		unique case (seq_q)
			rtys_pkg::PLANE_Y: begin
				job_last = !head.keep;
			end
			rtys_pkg::PLANE_CB: begin
				job_v    = head.vb;
				job_w    = cfg.wb;
				job_span = cfg.chroma_span;
				job_low  = cfg.chroma_low;
			end
			rtys_pkg::PLANE_CR: begin
				job_last = 1'b1;
				job_v    = head.vr;
				job_w    = cfg.wr;
				job_span = cfg.chroma_span;
				job_low  = cfg.chroma_low;
			end
			default: ;
		endcase
		pop = issue && job_last;
	end

	// Combinational helpers for the clamp, scale and divide stages
	always_comb begin
		den3 = $signed(rtys_pkg::N_W'(w_s3) << (rtys_pkg::F + 17));
		x4   = (rtys_pkg::X_W'(n_s4) << 8) - rtys_pkg::X_W'(n_s4)
			+ (rtys_pkg::X_W'(w_s4) << (rtys_pkg::F + 16));
		ds6  = div_step2(t_s5,   w_s5, 7);
		ds7  = div_step2(rem_s6, w_s6, 5);
		ds8  = div_step2(rem_s7, w_s7, 3);
		ds9  = div_step2(rem_s8, w_s8, 1);
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	// Mapping pipeline and four-stage divide
	always_ff @(posedge clk) begin
		// s1: selected job
		v_s1     <= job_v;
		w_s1     <= job_w;
		span_s1  <= job_span;
		low_s1   <= job_low;
		plane_s1 <= seq_q;
		last_s1  <= job_last;
		// s2: value times span, low end times divisor
		prod_a_s2 <= v_s1 * span_s1;
		prod_b_s2 <= low_s1 * w_s1;
		w_s2      <= w_s1;
		plane_s2  <= plane_s1;
		last_s2   <= last_s1;
		// s3: mapped numerator
		num_s3   <= prod_a_s2 + $signed(rtys_pkg::N_W'(prod_b_s2) << (rtys_pkg::F + 1));
		w_s3     <= w_s2;
		plane_s3 <= plane_s2;
		last_s3  <= last_s2;
		// s4: saturate to 0..denominator
		if (num_s3 < 0)
			n_s4 <= '0;
		else if (num_s3 > den3)
			n_s4 <= rtys_pkg::D_W'(den3);
		else
			n_s4 <= rtys_pkg::D_W'(num_s3);
		w_s4     <= w_s3;
		plane_s4 <= plane_s3;
		last_s4  <= last_s3;
		// s5: times 255 plus half, power-of-two part of the denominator removed
		t_s5     <= x4[rtys_pkg::F + 17 + rtys_pkg::TQ_W - 1 : rtys_pkg::F + 17];
		w_s5     <= w_s4;
		plane_s5 <= plane_s4;
		last_s5  <= last_s4;
		// s6..s9: quotient by the divisor, two bits a stage
		rem_s6   <= ds6.rem;
		q_s6     <= rtys_pkg::QUO_W'(ds6.q) << 6;
		w_s6     <= w_s5;
		plane_s6 <= plane_s5;
		last_s6  <= last_s5;
		rem_s7   <= ds7.rem;
		q_s7     <= q_s6 | (rtys_pkg::QUO_W'(ds7.q) << 4);
		w_s7     <= w_s6;
		plane_s7 <= plane_s6;
		last_s7  <= last_s6;
		rem_s8   <= ds8.rem;
		q_s8     <= q_s7 | (rtys_pkg::QUO_W'(ds8.q) << 2);
		w_s8     <= w_s7;
		plane_s8 <= plane_s7;
		last_s8  <= last_s7;
		q_s9     <= q_s8 | rtys_pkg::QUO_W'(ds9.q);
		plane_s9 <= plane_s8;
		last_s9  <= last_s8;
	end

	assign result_valid  = valid_s9;
	assign plane         = plane_s9;
	assign sample_byte   = q_s9;
	assign last_of_pixel = last_s9;

`ifndef ASSERT_OFF
	// Cb is always followed at once by Cr of the same pixel
	a_cb_then_cr: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s9 && plane_s9 == rtys_pkg::PLANE_CB) |=>
		(valid_s9 && plane_s9 == rtys_pkg::PLANE_CR))
		else $error("Cb not followed by Cr");
	// A luma result that does not close its pixel is followed by Cb
	a_y_then_cb: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s9 && plane_s9 == rtys_pkg::PLANE_Y && !last_s9) |=>
		(valid_s9 && plane_s9 == rtys_pkg::PLANE_CB))
		else $error("open luma result not followed by Cb");
	// Cr always closes a pixel, Cb never does
	a_last_plane: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s9 |-> ((plane_s9 == rtys_pkg::PLANE_CR) == last_s9
			|| plane_s9 == rtys_pkg::PLANE_Y))
		else $error("last flag on wrong plane");
`endif

endmodule

@@ design/rgb_to_ycbcr_subsampler.sv @@
// Top level of the RGB to YCbCr converter with 4:2:0, 4:2:2 and 4:4:4 chroma output.
//
// Pixel channel: a pixel (red, green, blue, column_odd, row_odd) transfers at a
// rising edge where start is high and busy is low. busy reflects queue credit only.
// Result channel: each result (plane, sample_byte, last_of_pixel) is shown for one
// cycle with result_valid high; the receiver cannot stall, so none is held back.
// Per pixel: Y always, then Cb and Cr at kept chroma positions; last_of_pixel
// marks the final result of the pixel.
// Config channel: cfg_index/cfg_data transfer on cfg_valid with cfg_ready, which
// is always high. Write only while no pixel is in flight.
// Path: the first result of a pixel passes 4 front stages, the queue and 9
// back stages, with no wait in the queue when the queue is empty.
// Throughput: one result per cycle through the back sequencer while the queue
// is not empty, so a luma-only pixel gives one result and a pixel with chroma
// gives three; an 8-entry queue absorbs the difference between the two.
// Reset: registers return to their defaults (BT.709-like weights, 4:2:0, full
// range) and all pipeline stages and the queue empty.
module rgb_to_ycbcr_subsampler (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [15:0]               red,
	input  logic signed [15:0]               green,
	input  logic signed [15:0]               blue,
	input  logic                             column_odd,
	input  logic                             row_odd,
	output logic                             result_valid,
	output logic [1:0]                       plane,
	output logic [7:0]                       sample_byte,
	output logic                             last_of_pixel,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rtys_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rtys_pkg::CFG_DATA_W-1:0]  cfg_data
);

	rtys_pkg::cfg_t        cfg;
	rtys_pkg::front_stat_t fstat;
	rtys_pkg::pix_t        push_data, head;
	logic                  accept, pop, empty;
	logic [rtys_pkg::Q_AW:0] q_count;
	logic [rtys_pkg::OCC_W-1:0] occupancy;

	// Credit: pixels in the front stages plus the queue never exceed its depth
	assign occupancy = rtys_pkg::OCC_W'(q_count) + rtys_pkg::OCC_W'(fstat.inflight);
	assign busy      = (occupancy >= rtys_pkg::OCC_W'(rtys_pkg::Q_DEPTH));
	assign accept    = start && !busy;

	rtys_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rtys_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.column_odd (column_odd),
		.row_odd    (row_odd),
		.cfg        (cfg),
		.stat       (fstat),
		.push_data  (push_data)
	);

	rtys_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fstat.push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.count     (q_count)
	);

	rtys_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.result_valid  (result_valid),
		.plane         (plane),
		.sample_byte   (sample_byte),
		.last_of_pixel (last_of_pixel)
	);

endmodule

@@ tb/ycbcr_sample_checker.sv @@
// Scoreboard for the RGB to YCbCr subsampler: predicts every output sample and compares.
module ycbcr_sample_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic signed [15:0]                  red,
	input  logic signed [15:0]                  green,
	input  logic signed [15:0]                  blue,
	input  logic                                column_odd,
	input  logic                                row_odd,
	input  logic                                result_valid,
	input  logic [1:0]                          plane,
	input  logic [7:0]                          sample_byte,
	input  logic                                last_of_pixel,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [rtys_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rtys_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                  fault_count,
	output int                                  pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint UNIT   = 1;
	localparam longint CH_ONE = UNIT << rtys_pkg::F;

	typedef struct packed {
		rtys_pkg::plane_t plane;
		logic [7:0]       value;
		logic             last;
	} ycc_sample_t;

	// Local copy of the register file
	logic [rtys_pkg::K_W-1:0] kb_q16;
	logic [rtys_pkg::K_W-1:0] kr_q16;
	logic [1:0]               format_code;
	logic [rtys_pkg::W_W-1:0] y_low;
	logic [rtys_pkg::W_W-1:0] y_high;
	logic [rtys_pkg::W_W-1:0] c_low;
	logic [rtys_pkg::W_W-1:0] c_high;

	ycc_sample_t pending_samples[$];

	// Add one predicted sample at the tail of the queue
	function automatic void append_sample(input ycc_sample_t s);
		pending_samples = {pending_samples, s};
	endfunction

	// Channel clamped to 0..one
	function automatic longint clamp_level(input logic signed [15:0] raw);
		longint v;
		v = raw;
		if (v < 0) v = 0;
		else if (v > CH_ONE) v = CH_ONE;
		return v;
	endfunction

	// num/den clamped to 0..1, scaled by 255 and rounded half up
	function automatic logic [7:0] saturate_byte(input longint num, input longint den);
		longint n;
		n = num;
		if (n < 0) n = 0;
		if (n > den) n = den;
		return 8'((n * 255 + den / 2) / den);
	endfunction

	// diff is channel*2^16 - Y, weight is 1-k in Q16
	function automatic logic [7:0] chroma_level(input longint diff, input longint weight);
		longint lo, hi, half, num, den;
		lo   = c_low;
		hi   = c_high;
		half = CH_ONE * weight;
		num  = (diff + half) * (hi - lo) + lo * weight * (UNIT << (rtys_pkg::F + 1));
		den  = weight * (UNIT << (rtys_pkg::F + 17));
		return saturate_byte(num, den);
	endfunction

	// Queue the samples one pixel produces
	function automatic void convert_pixel(input logic signed [15:0] r_raw,
			input logic signed [15:0] g_raw, input logic signed [15:0] b_raw,
			input logic col_odd, input logic row_is_odd);
		longint r, g, b, kb, kr, kg, y, lo, hi, ynum, yden;
		logic keep;
		ycc_sample_t s;
		r  = clamp_level(r_raw);
		g  = clamp_level(g_raw);
		b  = clamp_level(b_raw);
		kb = kb_q16;
		kr = kr_q16;
		kg = 65536 - kr - kb;
		y  = kr * r + kg * g + kb * b;
		lo = y_low;
		hi = y_high;
		ynum = y * (hi - lo) + lo * (UNIT << (rtys_pkg::F + 16));
		yden = UNIT << (rtys_pkg::F + 32);
		// top code bit set means full resolution, the spare code included
		if (format_code[1]) keep = 1'b1;
		else if (format_code == rtys_pkg::FMT_422) keep = !col_odd;
		else keep = !col_odd && !row_is_odd;
		s.plane = rtys_pkg::PLANE_Y;
		s.value = saturate_byte(ynum, yden);
		s.last  = !keep;
		append_sample(s);
		if (keep) begin
			s.plane = rtys_pkg::PLANE_CB;
			s.value = chroma_level(b * 65536 - y, 65536 - kb);
			s.last  = 1'b0;
			append_sample(s);
			s.plane = rtys_pkg::PLANE_CR;
			s.value = chroma_level(r * 65536 - y, 65536 - kr);
			s.last  = 1'b1;
			append_sample(s);
		end
	endfunction

	// Watch all three channels on each edge
	always @(posedge clk or negedge arst_n) begin
		ycc_sample_t want;
		if (!arst_n) begin
			kb_q16      <= rtys_pkg::KB_RESET;
			kr_q16      <= rtys_pkg::KR_RESET;
			format_code <= rtys_pkg::FMT_RESET;
			y_low       <= rtys_pkg::LOW_RESET;
			y_high      <= rtys_pkg::HIGH_RESET;
			c_low       <= rtys_pkg::LOW_RESET;
			c_high      <= rtys_pkg::HIGH_RESET;
			pending_samples.delete();
			fault_count   <= 0;
			pending_count <= 0;
		end else begin
			if (result_valid) begin
				if (pending_samples.size() == 0) begin
					$display("%0t: unexpected sample plane %0d byte %0d last %0b",
						$time, plane, sample_byte, last_of_pixel);
					fault_count <= fault_count + 1;
				end else begin
					want = pending_samples.pop_front();
					if ({plane, sample_byte, last_of_pixel} !==
							{want.plane, want.value, want.last}) begin
						$display("%0t: expected plane %0d byte %0d last %0b, got plane %0d byte %0d last %0b",
							$time, want.plane, want.value, want.last,
							plane, sample_byte, last_of_pixel);
						fault_count <= fault_count + 1;
					end
				end
			end
			// pixel transfer
			if (start && !busy)
				convert_pixel(red, green, blue, column_odd, row_odd);
			// register write
			if (cfg_valid && cfg_ready) begin
				case (rtys_pkg::cfg_reg_t'(cfg_index))
					rtys_pkg::CFG_KB:          kb_q16      <= cfg_data[rtys_pkg::K_W-1:0];
					rtys_pkg::CFG_KR:          kr_q16      <= cfg_data[rtys_pkg::K_W-1:0];
					rtys_pkg::CFG_FORMAT:      format_code <= cfg_data[1:0];
					rtys_pkg::CFG_LUMA_LOW:    y_low       <= cfg_data;
					rtys_pkg::CFG_LUMA_HIGH:   y_high      <= cfg_data;
					rtys_pkg::CFG_CHROMA_LOW:  c_low       <= cfg_data;
					rtys_pkg::CFG_CHROMA_HIGH: c_high      <= cfg_data;
					default: ;
				endcase
			end
			pending_count <= pending_samples.size();
		end
	end

endmodule

@@ tb/tb_rgb_to_ycbcr_subsampler.sv @@
// Testbench top for the RGB to YCbCr subsampler: stimulus, register settings and verdict.
module tb_rgb_to_ycbcr_subsampler;
	timeunit 1ns;
	timeprecision 1ps;

	// Spare format code, behaves as full resolution
	localparam logic [1:0] FMT_SPARE = 2'd3;
	localparam int PIXELS_PER_PHASE = 60;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            start = 1'b0;
	logic                            busy;
	logic signed [15:0]              red = '0;
	logic signed [15:0]              green = '0;
	logic signed [15:0]              blue = '0;
	logic                            column_odd = 1'b0;
	logic                            row_odd = 1'b0;
	logic                            result_valid;
	logic [1:0]                      plane;
	logic [7:0]                      sample_byte;
	logic                            last_of_pixel;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [rtys_pkg::CFG_IDX_W-1:0]  cfg_index = rtys_pkg::CFG_KB;
	logic [rtys_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	int                              fault_count;
	int                              pending_count;

	always #5ns clk = ~clk;

	rgb_to_ycbcr_subsampler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.red(red), .green(green), .blue(blue),
		.column_odd(column_odd), .row_odd(row_odd),
		.result_valid(result_valid), .plane(plane), .sample_byte(sample_byte),
		.last_of_pixel(last_of_pixel),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ycbcr_sample_checker u_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.red(red), .green(green), .blue(blue),
		.column_odd(column_odd), .row_odd(row_odd),
		.result_valid(result_valid), .plane(plane), .sample_byte(sample_byte),
		.last_of_pixel(last_of_pixel),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fault_count(fault_count), .pending_count(pending_count)
	);

	// One pixel transfer; start is left high for a back-to-back follower
	task automatic send_pixel(input logic signed [15:0] r, input logic signed [15:0] g,
			input logic signed [15:0] b, input logic col, input logic row, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		red        <= r;
		green      <= g;
		blue       <= b;
		column_odd <= col;
		row_odd    <= row;
		do @(posedge clk); while (busy);
	endtask

	// One register write transfer; valid is lowered by the caller
	task automatic write_reg(input rtys_pkg::cfg_reg_t idx,
			input logic [rtys_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input logic [rtys_pkg::K_W-1:0] kb,
			input logic [rtys_pkg::K_W-1:0] kr, input logic [1:0] fmt,
			input logic [rtys_pkg::W_W-1:0] ylo, input logic [rtys_pkg::W_W-1:0] yhi,
			input logic [rtys_pkg::W_W-1:0] clo, input logic [rtys_pkg::W_W-1:0] chi);
		write_reg(rtys_pkg::CFG_KB, rtys_pkg::CFG_DATA_W'(kb));
		write_reg(rtys_pkg::CFG_KR, rtys_pkg::CFG_DATA_W'(kr));
		write_reg(rtys_pkg::CFG_FORMAT, rtys_pkg::CFG_DATA_W'(fmt));
		write_reg(rtys_pkg::CFG_LUMA_LOW, ylo);
		write_reg(rtys_pkg::CFG_LUMA_HIGH, yhi);
		write_reg(rtys_pkg::CFG_CHROMA_LOW, clo);
		write_reg(rtys_pkg::CFG_CHROMA_HIGH, chi);
		cfg_valid <= 1'b0;
	endtask

	// Let every predicted sample come out, then keep the inputs quiet before the next phase
	task automatic drain;
		start <= 1'b0;
		@(negedge clk);
		while (pending_count != 0) @(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Mostly in-range levels, some full-width noise and the corners
	function automatic logic signed [15:0] pick_level();
		int sel;
		sel = $urandom_range(9);
		if (sel < 6) return 16'(int'($urandom_range(4224)) - 64);
		if (sel < 8) return 16'($urandom());
		if (sel == 8) begin
			case ($urandom_range(3))
				0: return 16'sd0;
				1: return 16'sd4096;
				2: return -16'sd32768;
				default: return 16'sd32767;
			endcase
		end
		return 16'(4096 - int'($urandom_range(15)));
	endfunction

	task automatic random_pixels(input int count, input int idle_pct);
		repeat (count)
			send_pixel(pick_level(), pick_level(), pick_level(),
				1'($urandom()), 1'($urandom()), idle_pct);
	endtask

	// Hard stop
	initial begin
		#2ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corners at reset settings (4:2:0), every parity
		send_pixel(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 0);
		send_pixel(16'sd4096, 16'sd4096, 16'sd4096, 1'b0, 1'b0, 0);
		send_pixel(16'sd4096, 16'sd0, 16'sd0, 1'b0, 1'b0, 0);
		send_pixel(16'sd0, 16'sd4096, 16'sd0, 1'b0, 1'b0, 0);
		send_pixel(16'sd0, 16'sd0, 16'sd4096, 1'b1, 1'b0, 0);
		send_pixel(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b1, 0);
		send_pixel(16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b1, 0);
		send_pixel(-16'sd1, 16'sd4097, 16'sd4095, 1'b0, 1'b0, 0);
		send_pixel(16'sd32767, -16'sd32768, 16'sd0, 1'b0, 1'b0, 0);
		send_pixel(16'sd0, -16'sd1, 16'sd32767, 1'b0, 1'b0, 0);
		send_pixel(16'sd2048, 16'sd2048, 16'sd2048, 1'b0, 1'b0, 0);
		send_pixel(16'sd4096, 16'sd0, 16'sd4096, 1'b0, 1'b0, 0);
		random_pixels(PIXELS_PER_PHASE, 84);
		drain();

		// Studio range, 4:2:2
		load_settings(16'd7471, 16'd19595, rtys_pkg::FMT_422, 17'd4112, 17'd60395,
			17'd4112, 17'd61681);
		random_pixels(PIXELS_PER_PHASE, 26);
		drain();

		// Zero blue and red weights, 4:4:4
		load_settings(16'd0, 16'd0, rtys_pkg::FMT_444, 17'd0, 17'd65536, 17'd0, 17'd65536);
		random_pixels(PIXELS_PER_PHASE, 0);
		drain();

		// Weights just under one each, spare format, inverted and above-one ranges
		load_settings(16'd65535, 16'd65535, FMT_SPARE, 17'd131071, 17'd0,
			17'd65536, 17'd131071);
		random_pixels(PIXELS_PER_PHASE, 84);
		drain();

		// Red weight at its top, ranges at the extremes, 4:2:0 again
		load_settings(16'd0, 16'd65535, rtys_pkg::FMT_420, 17'd0, 17'd131071,
			17'd131071, 17'd0);
		random_pixels(PIXELS_PER_PHASE, 26);
		drain();

		// Random settings, short burst back to back then idling
		load_settings(16'($urandom_range(65535)), 16'($urandom_range(65535)),
			2'($urandom_range(3)), 17'($urandom_range(131071)),
			17'($urandom_range(131071)), 17'($urandom_range(131071)),
			17'($urandom_range(131071)));
		random_pixels(PIXELS_PER_PHASE / 2, 0);
		random_pixels(PIXELS_PER_PHASE / 2, 84);
		drain();

		if (fault_count == 0 && pending_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
